/* design/ftsm_pkg.sv */
// Shared types and constants for the frame time spike monitor.
`timescale 1ns / 1ps
package ftsm_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW    = 6;
  localparam int CNT_W      = 7;
  localparam int ZONE_COUNT = 13;
  localparam int SUM_W      = 38;
  localparam int ENTRY_W    = 73;

  localparam logic [3:0]       NO_ZONE      = 4'd13;
  localparam logic [3:0]       PRESENT_ZONE = 4'd4;
  localparam logic [3:0]       LAST_PHASE   = 4'd3;
  localparam logic [CNT_W-1:0] NO_AGE       = 7'd64;

  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  localparam logic [1:0] REG_RATIO  = 2'd0;
  localparam logic [1:0] REG_DELTA  = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;

  typedef struct packed {
    logic [3:0]  ws;
    logic [3:0]  wp;
    logic        spike;
    logic [31:0] present;
    logic [31:0] cpu;
  } hist_entry_t;

endpackage

/* design/frame_time_spike_monitor.sv */
// Top level of the per-frame timing monitor with spike detection.
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  one word: function, zone, elapsed time
// m_*      out  m_tvalid/m_tready  frame statistics, one word per closed frame
// cfg_*    in   cfg_we             ratio, minimum delta, warmup frame count
//
// Begin and sample words are taken in the idle state. An end word on an open frame
// runs a zone sweep, two passes over the history RAM through its one read port,
// one multiply and up to three 38-step serial divisions (the first is skipped on
// an empty history). s_tready is low while an end word is worked. The result
// waits in an output register; the output step, and with it the input, stalls
// only while that register is still full. Reset (rst, synchronous) empties the
// history.
`timescale 1ns / 1ps
module frame_time_spike_monitor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // zone[3:0], elapsed_us[28:4], zero pad
  input  logic [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // history_count[6:0], spike_threshold_us[38:7], current_spike[39],
  // avg_cpu_work_us[71:40], max_cpu_work_us[103:72], max_cpu_age[110:104],
  // avg_present_us[142:111], max_present_us[174:143], spike_count[181:175],
  // latest_spike_age[188:182], worst_phase_zone[192:189],
  // worst_subsystem_zone[196:193], zero pad
  output logic [199:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata
);
  import ftsm_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_ZONES = 14'b00000000000010,
    ST_SCAN1 = 14'b00000000000100,
    ST_DIV1  = 14'b00000000001000,
    ST_DIV1W = 14'b00000000010000,
    ST_MUL   = 14'b00000000100000,
    ST_THR   = 14'b00000001000000,
    ST_PUSH  = 14'b00000010000000,
    ST_SCAN2 = 14'b00000100000000,
    ST_DIV2  = 14'b00001000000000,
    ST_DIV2W = 14'b00010000000000,
    ST_DIV3  = 14'b00100000000000,
    ST_DIV3W = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic [11:0] ratio;
  logic [23:0] delta;
  logic [6:0]  warmup;

  // frame accumulation
  logic        frame_open;
  logic [31:0] zone_totals [ZONE_COUNT];

  // history ring control
  logic [HIST_AW-1:0] write_ptr;
  logic [CNT_W-1:0]   fill;

  // input fields
  logic [1:0]  in_func;
  logic [3:0]  in_zone;
  logic [24:0] in_el;
  logic        s_acc;

  assign in_func  = s_tuser;
  assign in_zone  = s_tdata[3:0];
  assign in_el    = s_tdata[28:4];
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio  <= 12'd384;
      delta  <= 24'd2000;
      warmup <= 7'd30;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RATIO:  ratio  <= cfg_wdata[11:0];
        REG_DELTA:  delta  <= cfg_wdata;
        REG_WARMUP: warmup <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // zone sweep registers
  logic [3:0]  zidx;
  logic [31:0] zval;
  logic [32:0] cur_add;
  logic [31:0] cur, present, pbest, sbest;
  logic [3:0]  pid, sid;

  assign zval    = zone_totals[zidx];
  assign cur_add = {1'b0, cur} + {1'b0, zval};

  // sample add with saturation
  logic [32:0] samp_add;
  assign samp_add = {1'b0, zone_totals[in_zone]} + 33'(in_el[23:0]);

  // history RAM and scan
  hist_entry_t        wr_entry, rd_entry;
  logic [HIST_AW-1:0] raddr;
  logic [CNT_W-1:0]   scan_age, rd_age;
  logic               rd_vld, issue, ram_we;

  assign issue  = (state == ST_SCAN1 || state == ST_SCAN2) && (scan_age < fill);
  assign raddr  = write_ptr - HIST_AW'(1) - scan_age[HIST_AW-1:0];
  assign ram_we = (state == ST_PUSH);

  ftsm_ram #(.WIDTH(ENTRY_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // statistics accumulators
  logic [SUM_W-1:0] sum, psum;
  logic [31:0]      avg, maxw, maxp, thr, avg_cpu;
  logic [CNT_W-1:0] maxage, spk, lspk;
  logic [3:0]       mwp, mws;
  logic             spike;
  logic [43:0]      prod;

  // threshold compare
  logic [35:0] thr_a, thr_b, thr_mx;
  logic [31:0] thr_sat;
  logic        warm;
  assign thr_a   = prod[43:8];
  assign thr_b   = 36'({1'b0, avg} + 33'(delta));
  assign thr_mx  = (thr_a > thr_b) ? thr_a : thr_b;
  assign thr_sat = (|thr_mx[35:32]) ? 32'hFFFF_FFFF : thr_mx[31:0];
  assign warm    = fill >= warmup;

  always_comb begin
    wr_entry.cpu     = cur;
    wr_entry.present = present;
    wr_entry.spike   = spike;
    wr_entry.wp      = pid;
    wr_entry.ws      = sid;
  end

  // shared divider
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_dividend;
  logic [31:0]      div_q;
  assign div_start    = (state == ST_DIV1) || (state == ST_DIV2) || (state == ST_DIV3);
  assign div_dividend = (state == ST_DIV3) ? psum : sum;

  ftsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      frame_open <= 1'b0;
      write_ptr  <= '0;
      fill       <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_age <= scan_age;
      if (issue) begin
        scan_age <= scan_age + CNT_W'(1);
      end
      // output register: load from the output step, else free on handshake
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            unique case (in_func)
              FUNC_BEGIN: begin
                for (int i = 0; i < ZONE_COUNT; i++) begin
                  zone_totals[i] <= '0;
                end
                frame_open <= 1'b1;
              end
              FUNC_SAMPLE: begin
                if (frame_open && in_zone < 4'(ZONE_COUNT) && !in_el[24]) begin
                  zone_totals[in_zone] <= samp_add[32] ? 32'hFFFF_FFFF : samp_add[31:0];
                end
              end
              FUNC_END: begin
                if (frame_open) begin
                  zidx  <= '0;
                  cur   <= '0;
                  pbest <= '0;
                  sbest <= '0;
                  pid   <= NO_ZONE;
                  sid   <= NO_ZONE;
                  state <= ST_ZONES;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ZONES: begin
          if (zidx <= LAST_PHASE) begin
            cur <= cur_add[32] ? 32'hFFFF_FFFF : cur_add[31:0];
            if (zval > pbest) begin
              pbest <= zval;
              pid   <= zidx;
            end
          end else if (zidx == PRESENT_ZONE) begin
            present <= zval;
          end else if (zval > sbest) begin
            sbest <= zval;
            sid   <= zidx;
          end
          zidx <= zidx + 4'd1;
          if (zidx == 4'(ZONE_COUNT - 1)) begin
            scan_age <= '0;
            sum      <= '0;
            state    <= ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          if (rd_vld) begin
            sum <= sum + SUM_W'(rd_entry.cpu);
          end
          if (!issue && !rd_vld) begin
            if (fill == '0) begin
              avg   <= '0;
              state <= ST_MUL;
            end else begin
              state <= ST_DIV1;
            end
          end
        end
        ST_DIV1:  state <= ST_DIV1W;
        ST_DIV1W: begin
          if (div_done) begin
            avg   <= div_q;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= avg * ratio;
          state <= ST_THR;
        end
        ST_THR: begin
          thr   <= warm ? thr_sat : '0;
          spike <= warm && (cur > thr_sat);
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          write_ptr  <= write_ptr + HIST_AW'(1);
          if (fill < CNT_W'(HIST_DEPTH)) begin
            fill <= fill + CNT_W'(1);
          end
          frame_open <= 1'b0;
          scan_age   <= '0;
          sum        <= '0;
          psum       <= '0;
          maxw       <= '0;
          maxp       <= '0;
          maxage     <= NO_AGE;
          spk        <= '0;
          lspk       <= NO_AGE;
          mwp        <= NO_ZONE;
          mws        <= NO_ZONE;
          state      <= ST_SCAN2;
        end
        ST_SCAN2: begin
          if (rd_vld) begin
            sum  <= sum + SUM_W'(rd_entry.cpu);
            psum <= psum + SUM_W'(rd_entry.present);
            if (rd_age == '0 || rd_entry.cpu > maxw) begin
              maxw   <= rd_entry.cpu;
              maxage <= rd_age;
              mwp    <= rd_entry.wp;
              mws    <= rd_entry.ws;
            end
            if (rd_entry.present > maxp) begin
              maxp <= rd_entry.present;
            end
            if (rd_entry.spike) begin
              spk <= spk + CNT_W'(1);
              if (lspk == NO_AGE) begin
                lspk <= rd_age;
              end
            end
          end
          if (!issue && !rd_vld) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2:  state <= ST_DIV2W;
        ST_DIV2W: begin
          if (div_done) begin
            avg_cpu <= div_q;
            state   <= ST_DIV3;
          end
        end
        ST_DIV3:  state <= ST_DIV3W;
        ST_DIV3W: begin
          if (div_done) begin
            avg   <= div_q;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, mws, mwp, lspk, spk, maxp, avg, maxage, maxw,
                         avg_cpu, spike, thr, fill};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result word raised outside the output step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(HIST_DEPTH))
    else $error("history fill beyond depth");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1W || state == ST_DIV2W || state == ST_DIV3W))
    else $error("divider finished while no division awaited");

  a_scan2_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN2 |-> fill != '0)
    else $error("statistics pass over empty history");
`endif

endmodule

/* design/ftsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ftsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ftsm_div.sv */
// Restoring serial divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module ftsm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ftsm_pkg::SUM_W-1:0]  dividend,
  input  logic [ftsm_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [31:0]                 quotient
);
  import ftsm_pkg::*;

  logic                 busy;
  logic [5:0]           cnt;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W:0]       trial;
  logic                 qbit;
  logic [CNT_W-1:0]     rem_next;

  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    qbit     = trial >= {1'b0, divisor};
    rem_next = qbit ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[SUM_W-2:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[31:0];

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the frame time spike monitor.
`timescale 1ns / 1ps
module tb_top;
  import ftsm_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // zone[3:0], elapsed_us[28:4], zero pad
  logic [1:0]   s_tuser;   // func[1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [199:0] m_tdata;   // frame statistics, packed as in the block header
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [23:0]  cfg_wdata;

  frame_time_spike_monitor u_dut (.*);

  typedef struct packed {
    logic [3:0]  ws_zone;
    logic [3:0]  wp_zone;
    logic [6:0]  last_spike_age;
    logic [6:0]  spikes;
    logic [31:0] present_max;
    logic [31:0] present_avg;
    logic [6:0]  cpu_max_age;
    logic [31:0] cpu_max;
    logic [31:0] cpu_avg;
    logic        spike;
    logic [31:0] threshold;
    logic [6:0]  fill;
  } frame_stats_t;

  // Local copy of the monitor state.
  logic [11:0] ratio_q8;
  logic [23:0] min_delta;
  logic [6:0]  warmup;
  logic        open_frame;
  logic [31:0] totals [16];
  logic [31:0] h_cpu [HIST_DEPTH];
  logic [31:0] h_present [HIST_DEPTH];
  logic        h_spike [HIST_DEPTH];
  logic [3:0]  h_wp [HIST_DEPTH];
  logic [3:0]  h_ws [HIST_DEPTH];
  int          wr_slot;
  int          fill_cnt;

  frame_stats_t stats_q[$];
  int  mismatches;
  int  cycles;
  int  hold_reqs;   // long receiver stalls requested by the tests
  int  hold_done;   // requests taken up by the receiver
  int  hold_off;    // forced receiver stall, counted in its own process
  int  rx_wait;     // receiver idle cycles left before the next word

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout guard: ends the run as failed once the cycle counter passes its limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {32'd0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [3:0] worst_zone(int first, int last);
    logic [31:0] best;
    logic [3:0]  id;
    best = 0;
    id = NO_ZONE;
    for (int z = first; z <= last; z++)
      if (totals[z] > best) begin
        best = totals[z];
        id = z[3:0];
      end
    return id;
  endfunction

  function automatic int age_slot(int age);
    return (wr_slot + 2 * HIST_DEPTH - 1 - age) % HIST_DEPTH;
  endfunction

  // Advances the local state by one word; returns 1 when a result follows.
  function automatic bit predict_word(logic [1:0] fn, logic [3:0] zn,
                                      logic [24:0] el, output frame_stats_t st);
    logic [63:0] sum, psum, avg, a, b, thr;
    logic [31:0] cur, w, p, maxw, maxp;
    int          s, maxage, spk, lspk;
    bit          spike;
    st = '0;
    if (fn == FUNC_BEGIN) begin
      foreach (totals[i]) totals[i] = 0;
      open_frame = 1'b1;
      return 0;
    end
    if (fn == FUNC_SAMPLE) begin
      if (open_frame && zn < ZONE_COUNT && !el[24])
        totals[zn] = sat_add(totals[zn], {40'd0, el[23:0]});
      return 0;
    end
    if (fn != FUNC_END || !open_frame) return 0;

    sum = 0;
    for (int i = 0; i < fill_cnt; i++) sum += h_cpu[age_slot(i)];
    avg = fill_cnt ? sum / fill_cnt : 0;
    cur = sat_add(sat_add(sat_add(totals[0], totals[1]), totals[2]), totals[3]);
    thr = 0;
    spike = 0;
    if (fill_cnt >= warmup) begin
      a = (avg * ratio_q8) >> 8;
      b = avg + min_delta;
      thr = (a > b) ? a : b;
      if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
      spike = cur > thr;
    end

    h_cpu[wr_slot] = cur;
    h_present[wr_slot] = totals[PRESENT_ZONE];
    h_spike[wr_slot] = spike;
    h_wp[wr_slot] = worst_zone(0, 3);
    h_ws[wr_slot] = worst_zone(5, 12);
    wr_slot = (wr_slot + 1) % HIST_DEPTH;
    if (fill_cnt < HIST_DEPTH) fill_cnt++;
    open_frame = 1'b0;

    sum = 0;
    psum = 0;
    maxw = 0;
    maxp = 0;
    maxage = 0;
    spk = 0;
    lspk = NO_AGE;
    for (int i = 0; i < fill_cnt; i++) begin
      s = age_slot(i);
      w = h_cpu[s];
      p = h_present[s];
      sum += w;
      psum += p;
      if (i == 0 || w > maxw) begin
        maxw = w;
        maxage = i;
      end
      if (p > maxp) maxp = p;
      if (h_spike[s]) begin
        spk++;
        if (lspk == NO_AGE) lspk = i;
      end
    end
    s = age_slot(maxage);
    st.fill = fill_cnt[6:0];
    st.threshold = thr[31:0];
    st.spike = spike;
    st.cpu_avg = 32'(sum / fill_cnt);
    st.cpu_max = maxw;
    st.cpu_max_age = maxage[6:0];
    st.present_avg = 32'(psum / fill_cnt);
    st.present_max = maxp;
    st.spikes = spk[6:0];
    st.last_spike_age = lspk[6:0];
    st.wp_zone = h_wp[s];
    st.ws_zone = h_ws[s];
    return 1;
  endfunction

  // Receiver: a random idle gap drawn per word, plus a long hold-off on request.
  always @(posedge clk) begin
    int rx_gap;
    if (rst) begin
      m_tready  <= 1'b0;
      rx_wait   <= 0;
      hold_off  <= 0;
      hold_done <= 0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_off  <= 3000;
      m_tready  <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_gap = $urandom_range(0, 17);
      rx_wait  <= rx_gap;
      m_tready <= (rx_gap == 0);
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker: compares each word with the oldest expectation.
  always @(posedge clk) begin
    frame_stats_t exp_st, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[196:0];
      if (stats_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_st = stats_q.pop_front();
        if (got !== exp_st) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %p\n          actual   %p", exp_st, got);
        end
      end
    end
  end

  // Leaves s_tvalid high after acceptance; the next step that is not a word
  // back to back drops it.
  task automatic send_word(logic [1:0] fn, logic [3:0] zn, logic [24:0] el,
                           bit no_gap = 0);
    frame_stats_t st;
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {3'd0, el, zn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (predict_word(fn, zn, el, st)) stats_q.push_back(st);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RATIO:  ratio_q8 = val[11:0];
      REG_DELTA:  min_delta = val;
      REG_WARMUP: warmup = val[6:0];
      default: ;
    endcase
  endtask

  // Wait for all results, then let a trailing end pass settle.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // One well-formed frame with random content.
  task automatic send_frame(int samples, int max_us);
    send_word(FUNC_BEGIN, 4'($urandom), 25'($urandom));
    repeat (samples)
      send_word(FUNC_SAMPLE, 4'($urandom_range(0, 12)),
                25'($urandom_range(0, max_us)));
    send_word(FUNC_END, 4'($urandom), 25'($urandom));
  endtask

  task automatic test_directed;
    send_word(FUNC_END, 4'd0, 25'd5);            // end while closed
    send_word(FUNC_SAMPLE, 4'd0, 25'd5);         // sample while closed
    send_word(2'd3, 4'd15, 25'h1FF_FFFF);        // unused function
    send_word(FUNC_BEGIN, 4'd0, 25'd0);
    send_word(FUNC_SAMPLE, 4'd0, 25'hFF_FFFF);
    send_word(FUNC_SAMPLE, 4'd0, 25'hFF_FFFF);
    send_word(FUNC_BEGIN, 4'd0, 25'd0);          // begin while open clears
    send_word(FUNC_SAMPLE, 4'd13, 25'd100);      // invalid zones
    send_word(FUNC_SAMPLE, 4'd15, 25'd100);
    send_word(FUNC_SAMPLE, 4'd2, 25'h100_0000);  // negative sample
    send_word(FUNC_SAMPLE, 4'd1, 25'h1FF_FFFF);
    send_word(FUNC_END, 4'd0, 25'd0);            // all-zero frame
    send_word(FUNC_BEGIN, 4'd0, 25'd0);
    for (int z = 0; z < 4; z++) begin
      send_word(FUNC_SAMPLE, 4'(z), 25'hFF_FFFF);
      send_word(FUNC_SAMPLE, 4'(z), 25'hFF_FFFF);
    end
    send_word(FUNC_SAMPLE, 4'd4, 25'hFF_FFFF);
    send_word(FUNC_SAMPLE, 4'd12, 25'd7);
    send_word(FUNC_END, 4'd0, 25'd0);            // large engine work
    drain();
  endtask

  task automatic test_config_sweep;
    // Zero warmup, extreme ratio: detection from the first frame.
    write_reg(REG_RATIO, 24'd4095);
    write_reg(REG_DELTA, 24'd0);
    write_reg(REG_WARMUP, 24'd0);
    repeat (12) send_frame($urandom_range(0, 4), 3000);
    drain();
    write_reg(REG_RATIO, 24'd0);
    write_reg(REG_DELTA, 24'hFF_FFFF);
    write_reg(REG_WARMUP, 24'd64);
    repeat (10) send_frame($urandom_range(0, 4), 24'hFF_FFFF);
    drain();
    write_reg(REG_WARMUP, 24'd127);              // never enabled
    repeat (6) send_frame(2, 5000);
    drain();
    write_reg(REG_RATIO, 24'd300);
    write_reg(REG_DELTA, 24'd50);
    write_reg(REG_WARMUP, 24'd4);
  endtask

  // Receiver blocked while frames keep coming: the input must stall.
  task automatic test_backpressure;
    hold_reqs = hold_reqs + 1;
    repeat (6) send_frame(1, 2000);
    drain();
  endtask

  task automatic test_random;
    int n;
    n = 0;
    while (n < 230) begin
      if ($urandom_range(0, 9) < 8) begin
        int k;
        k = $urandom_range(0, 5);
        // mostly small times, some spikes to trigger detection
        send_frame(k, ($urandom_range(0, 7) == 0) ? 40000 : 1500);
        n += k + 2;
      end else begin
        send_word(2'($urandom), 4'($urandom), 25'($urandom));
        n++;
      end
      if ($urandom_range(0, 40) == 0) begin
        drain();
      end
    end
    // back-to-back burst, no idling on the input side
    repeat (8) begin
      send_word(FUNC_BEGIN, 4'd0, 25'd0, 1);
      send_word(FUNC_SAMPLE, 4'($urandom_range(0, 4)), 25'($urandom_range(0, 9000)), 1);
      send_word(FUNC_END, 4'd0, 25'd0, 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cycles = 0;
    mismatches = 0;
    hold_reqs = 0;
    ratio_q8 = 12'd384;
    min_delta = 24'd2000;
    warmup = 7'd30;
    open_frame = 1'b0;
    wr_slot = 0;
    fill_cnt = 0;
    foreach (totals[i]) totals[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
